### rtl/bitwise_register_machine_fib_read_assert.svh
// Assertion macros shared by the register machine RTL files.
`ifndef BITWISE_REGISTER_MACHINE_FIB_READ_ASSERT_SVH
`define BITWISE_REGISTER_MACHINE_FIB_READ_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BRMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/brmf_pkg.sv
// Types, constants and functions shared by the register machine modules.
package brmf_pkg;

	localparam int NUM_REGS = 128;
	localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int IDX_W = 7;
	localparam int DATA_W = 32;
	localparam int SH_W = 5;
	localparam int FIB_W = 24;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int GRP = 8;
	localparam int NGRP = DATA_W / GRP;

	typedef enum logic [2:0] {
		OP_AND   = 3'd0,
		OP_OR    = 3'd1,
		OP_XOR   = 3'd2,
		OP_NOT   = 3'd3,
		OP_SHL   = 3'd4,
		OP_SHR   = 3'd5,
		OP_LOAD  = 3'd6,
		OP_READ  = 3'd7
	} op_t;

	// One classified operation as it waits in the queue.
	typedef struct packed {
		op_t                 op;
		logic                is_read;
		logic                dest_ok;
		logic                a_ok;
		logic                b_ok;
		logic [REG_AW-1:0]   dest;
		logic [REG_AW-1:0]   src_a;
		logic [REG_AW-1:0]   src_b;
		logic [SH_W-1:0]     shamt;
		logic [DATA_W-1:0]   load_value;
	} item_t;

	// Weight of bit i is F(i+2).
	localparam logic [FIB_W-1:0] FIB_WEIGHT [DATA_W] = '{
		24'd1, 24'd2, 24'd3, 24'd5, 24'd8, 24'd13, 24'd21, 24'd34,
		24'd55, 24'd89, 24'd144, 24'd233, 24'd377, 24'd610, 24'd987, 24'd1597,
		24'd2584, 24'd4181, 24'd6765, 24'd10946, 24'd17711, 24'd28657, 24'd46368,
		24'd75025, 24'd121393, 24'd196418, 24'd317811, 24'd514229, 24'd832040,
		24'd1346269, 24'd2178309, 24'd3524578
	};

	function automatic logic [REG_AW-1:0] reg_addr(input logic [IDX_W-1:0] idx);
		logic [REG_AW+IDX_W-1:0] w;
		w = {{REG_AW{1'b0}}, idx};
		return w[REG_AW-1:0];
	endfunction

	function automatic logic reg_ok(input logic [IDX_W-1:0] idx);
		logic [IDX_W:0] w;
		w = {1'b0, idx};
		return (32'(w) < NUM_REGS);
	endfunction

	// Weighted sum of one byte of the word; grp selects which byte.
	function automatic logic [FIB_W-1:0] fib_part(input logic [GRP-1:0] bits,
		input int grp);
		logic [FIB_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < GRP; i++) begin
			if (bits[i]) begin
				acc = acc + FIB_WEIGHT[grp * GRP + i];
			end
		end
		return acc;
	endfunction

endpackage

### rtl/brmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/brmf_front.sv
// Front end: accepts operations, classifies them and queues them for the back end.
`include "bitwise_register_machine_fib_read_assert.svh"
module brmf_front import brmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           op,
	input  logic [IDX_W-1:0]     dest,
	input  logic [IDX_W-1:0]     src_a,
	input  logic [IDX_W-1:0]     src_b,
	input  logic [SH_W-1:0]      shift_amount,
	input  logic [DATA_W-1:0]    load_value,
	output logic                 q_valid,
	output item_t                q_head,
	input  logic                 q_pop
);

	item_t               q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	item_t               cls;
	logic                push;

	// Decode and range-check the incoming transfer.
	always_comb begin
		cls.op         = op_t'(op);
		cls.is_read    = (op_t'(op) == OP_READ);
		cls.dest_ok    = reg_ok(dest);
		cls.a_ok       = reg_ok(src_a);
		cls.b_ok       = reg_ok(src_b);
		cls.dest       = reg_addr(dest);
		cls.src_a      = reg_addr(src_a);
		cls.src_b      = reg_addr(src_b);
		cls.shamt      = shift_amount;
		cls.load_value = load_value;
	end

	assign in_stall = (count_q == QCNT_W'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_head   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BRMF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue overfilled")
	`BRMF_ASSERT_NEXT(a_push_not_empty, push && !q_pop, q_valid, "pushed entry lost")

endmodule

### rtl/brmf_back.sv
// Back end: register file, operand fetch with bypass, ALU and readout register.
`include "bitwise_register_machine_fib_read_assert.svh"
module brmf_back import brmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  item_t                q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    raw_bits,
	output logic [FIB_W-1:0]     fib_value
);

	logic [NUM_REGS-1:0]  vld_q;
	logic                 s1_valid_q;
	item_t                item_s1;
	logic                 hit_a_s1;
	logic                 hit_b_s1;
	logic                 vld_a_s1;
	logic                 vld_b_s1;
	logic [DATA_W-1:0]    byp_s1;
	logic [DATA_W-1:0]    rdata_a;
	logic [DATA_W-1:0]    rdata_b;
	logic [DATA_W-1:0]    opa;
	logic [DATA_W-1:0]    opb;
	logic [DATA_W-1:0]    alu;
	logic                 exec_go;
	logic                 wr_en;
	logic                 out_ld;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    raw_q;
	logic [FIB_W-1:0]     part_q [NGRP];
	logic [FIB_W-1:0]     fib_sum;

	// A read waits for the readout register; everything else executes at once.
	assign exec_go = s1_valid_q && (!item_s1.is_read || !out_valid_q || !out_stall);
	assign q_pop   = q_valid && (!s1_valid_q || exec_go);
	assign wr_en   = exec_go && !item_s1.is_read && item_s1.dest_ok;
	assign out_ld  = exec_go && item_s1.is_read;

	brmf_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (item_s1.dest),
		.wr_data (alu),
		.rd_en   (q_pop),
		.rd_addr (q_head.src_a),
		.rd_data (rdata_a)
	);

	brmf_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (item_s1.dest),
		.wr_data (alu),
		.rd_en   (q_pop),
		.rd_addr (q_head.src_b),
		.rd_data (rdata_b)
	);

	// Registers never written since reset read as zero.
	assign opa = hit_a_s1 ? byp_s1 : (vld_a_s1 ? rdata_a : '0);
	assign opb = hit_b_s1 ? byp_s1 : (vld_b_s1 ? rdata_b : '0);

	always_comb begin
		unique case (item_s1.op)
			OP_AND:  alu = opa & opb;
			OP_OR:   alu = opa | opb;
			OP_XOR:  alu = opa ^ opb;
			OP_NOT:  alu = ~opa;
			OP_SHL:  alu = opa << item_s1.shamt;
			OP_SHR:  alu = opa >> item_s1.shamt;
			OP_LOAD: alu = item_s1.load_value;
			OP_READ: alu = opa;
		endcase
	end

	// Operand stage payload, with the result being written this cycle forwarded.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1  <= q_head;
			hit_a_s1 <= wr_en && q_head.a_ok && (item_s1.dest == q_head.src_a);
			hit_b_s1 <= wr_en && q_head.b_ok && (item_s1.dest == q_head.src_b);
			vld_a_s1 <= q_head.a_ok && vld_q[q_head.src_a];
			vld_b_s1 <= q_head.b_ok && vld_q[q_head.src_b];
			byp_s1   <= alu;
		end
		if (out_ld) begin
			raw_q <= opa;
			for (int g = 0; g < NGRP; g++) begin
				part_q[g] <= fib_part(opa[g*GRP +: GRP], g);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[item_s1.dest] <= 1'b1;
			end
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (exec_go) begin
				s1_valid_q <= 1'b0;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		fib_sum = '0;
		for (int g = 0; g < NGRP; g++) begin
			fib_sum = fib_sum + part_q[g];
		end
	end

	assign out_valid = out_valid_q;
	assign raw_bits  = raw_q;
	assign fib_value = fib_sum;

	`BRMF_ASSERT_NEXT(a_pop_fills_s1, q_pop, s1_valid_q, "popped item not in operand stage")
	`BRMF_ASSERT_NEXT(a_read_loads_out, out_ld, out_valid_q, "read result not presented")
	`BRMF_ASSERT_NEXT(a_write_marks_valid, wr_en, vld_q[$past(item_s1.dest)],
		"written register not marked valid")

endmodule

### rtl/bitwise_register_machine_fib_read.sv
// Top level of the register machine with a Fibonacci-weighted readout.
// The block holds NUM_REGS registers of 32 bits, all zero after reset.
// Input channel: in_valid / in_stall with fields op, dest, src_a, src_b,
// shift_amount and load_value; a transfer happens at a clock edge where in_valid
// is high and in_stall is low. Each transfer is one operation.
// AND, OR, XOR, NOT, the two logical shifts and LOAD update register dest and
// produce nothing on the output. READ produces one output transfer carrying
// raw_bits, the contents of src_a, and fib_value, their weighted sum.
// Output channel: out_valid / out_stall; the payload holds while stalled.
// A READ goes from the queue through the operand stage to the readout register.
// One operation per cycle unless a READ is held. Two register file copies give both
// operands in the cycle after issue, and a write from the execute stage is
// forwarded to an operand fetched in the same cycle, so back-to-back dependent
// operations do not wait. A two-entry queue separates intake from execution.
// When out_stall holds a presented result, a following READ waits in the
// execute stage, the queue fills, and in_stall rises after two more transfers.
// Writes continue while only the output side is blocked and the queue has room.
// Reset (arst_n low, asynchronous) empties the queue and pipeline and marks every
// register as never written, so all read as zero; no clearing pass is needed.
module bitwise_register_machine_fib_read import brmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           op,
	input  logic [IDX_W-1:0]     dest,
	input  logic [IDX_W-1:0]     src_a,
	input  logic [IDX_W-1:0]     src_b,
	input  logic [SH_W-1:0]      shift_amount,
	input  logic [DATA_W-1:0]    load_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    raw_bits,
	output logic [FIB_W-1:0]     fib_value
);

	// Queue head and handshake between the front and back ends.
	logic   q_valid;
	item_t  q_head;
	logic   q_pop;

	// The front end decodes each transfer, checks the indexes against the file
	// size and holds up to QDEPTH operations.
	brmf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.dest         (dest),
		.src_a        (src_a),
		.src_b        (src_b),
		.shift_amount (shift_amount),
		.load_value   (load_value),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop)
	);

	// The back end fetches operands, executes and owns the output register.
	brmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.raw_bits  (raw_bits),
		.fib_value (fib_value)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for the register machine with a Fibonacci-weighted readout.
`timescale 1ns / 100ps

module tb;
	import brmf_pkg::*;

	// The run is stopped here if the results never arrive.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS = 640;
	localparam int DRAIN_CYCLES = 8;

	// One expected READ result: the raw word and its weighted sum.
	typedef struct packed {
		logic [DATA_W-1:0] raw;
		logic [FIB_W-1:0]  fib;
	} read_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        op = OP_AND;
	logic [IDX_W-1:0]  dest = '0;
	logic [IDX_W-1:0]  src_a = '0;
	logic [IDX_W-1:0]  src_b = '0;
	logic [SH_W-1:0]   shift_amount = '0;
	logic [DATA_W-1:0] load_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] raw_bits;
	logic [FIB_W-1:0]  fib_value;

	// Predicted contents of the register file and the READ results still owed.
	logic [DATA_W-1:0] reg_file_model [NUM_REGS];
	read_result_t      pending_reads [$];

	int error_count = 0;
	int cycle_count = 0;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// A long receiver hold-off is requested by bumping hold_id; the receiver
	// process picks up hold_len and counts it down on its own.
	int hold_id = 0;
	int hold_len = 0;

	bitwise_register_machine_fib_read dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.dest         (dest),
		.src_a        (src_a),
		.src_b        (src_b),
		.shift_amount (shift_amount),
		.load_value   (load_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.raw_bits     (raw_bits),
		.fib_value    (fib_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Global watchdog. Every run either finishes normally or is cut off here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bitwise_register_machine_fib_read: mismatch");
			$finish;
		end
	end

	// Sum of F(i+2) over the set bits i. The weights are generated by the
	// recurrence as the loop walks up the word, starting from 1 and 2.
	function automatic logic [FIB_W-1:0] fib_weighted_sum(input logic [DATA_W-1:0] bits);
		logic [31:0] w_lo;
		logic [31:0] w_hi;
		logic [31:0] w_next;
		logic [31:0] acc;
		w_lo = 32'd1;
		w_hi = 32'd2;
		acc = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (bits[i]) begin
				acc = acc + w_lo;
			end
			w_next = w_lo + w_hi;
			w_lo = w_hi;
			w_hi = w_next;
		end
		return acc[FIB_W-1:0];
	endfunction

	// A source index beyond the file reads as zero.
	function automatic logic [DATA_W-1:0] model_read(input logic [IDX_W-1:0] idx);
		if (int'(idx) < NUM_REGS) begin
			return reg_file_model[idx];
		end
		return '0;
	endfunction

	// Applies one accepted operation to the register file copy. Both sources are
	// fetched before dest is written, so dest may equal either source. A write
	// to an index beyond the file is dropped.
	task automatic predict_operation(input op_t code, input logic [IDX_W-1:0] d,
		input logic [IDX_W-1:0] a_idx, input logic [IDX_W-1:0] b_idx,
		input logic [SH_W-1:0] sh, input logic [DATA_W-1:0] lv);
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] wr;
		read_result_t      res;
		a = model_read(a_idx);
		b = model_read(b_idx);
		wr = '0;
		case (code)
			OP_AND:  wr = a & b;
			OP_OR:   wr = a | b;
			OP_XOR:  wr = a ^ b;
			OP_NOT:  wr = ~a;
			OP_SHL:  wr = a << sh;
			OP_SHR:  wr = a >> sh;
			OP_LOAD: wr = lv;
			default: wr = '0;
		endcase
		if (code == OP_READ) begin
			res.raw = a;
			res.fib = fib_weighted_sum(a);
			pending_reads = {pending_reads, res};
		end else if (int'(d) < NUM_REGS) begin
			reg_file_model[d] = wr;
		end
	endtask

	// Monitor and scoreboard. Signals are sampled right at the rising edge, before
	// any nonblocking update of that edge, so both sides see the same values. An
	// input transfer feeds the predictor; an output transfer is compared with the
	// oldest result still owed.
	always @(posedge clk) begin
		read_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				$error("unexpected result: raw_bits %h fib_value %0d", raw_bits, fib_value);
				error_count++;
			end else begin
				exp_res = pending_reads.pop_front();
				if (raw_bits !== exp_res.raw) begin
					$error("raw_bits: expected %h, actual %h", exp_res.raw, raw_bits);
					error_count++;
				end
				if (fib_value !== exp_res.fib) begin
					$error("fib_value: expected %0d, actual %0d", exp_res.fib, fib_value);
					error_count++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			predict_operation(op_t'(op), dest, src_a, src_b, shift_amount, load_value);
		end
	end

	// Receiver. It stalls at random at the current percentage, except while a
	// requested hold-off is running, when it stalls every cycle.
	always @(posedge clk) begin
		int hold_taken;
		int hold_left;
		if (hold_id != hold_taken) begin
			hold_taken = hold_id;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Offers one operation and returns after the edge at which it transferred.
	// Valid stays high on return so that the next call can follow directly;
	// only an idle cycle or wait_results_drained lowers it.
	task automatic send_op(input op_t code, input logic [IDX_W-1:0] d,
		input logic [IDX_W-1:0] a_idx, input logic [IDX_W-1:0] b_idx,
		input logic [SH_W-1:0] sh, input logic [DATA_W-1:0] lv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		dest <= d;
		src_a <= a_idx;
		src_b <= b_idx;
		shift_amount <= sh;
		load_value <= lv;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// The sender goes quiet until every owed result has come back.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Indices mostly come from a small pool so that operations depend on each
	// other; now and then any register of the file is used.
	function automatic logic [IDX_W-1:0] pick_index();
		if ($urandom_range(0, 3) == 0) begin
			return IDX_W'($urandom_range(0, 127));
		end
		return IDX_W'($urandom_range(0, 7));
	endfunction

	// Words with a bias toward all zeros, all ones and single bits.
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return DATA_W'(1) << $urandom_range(0, 31);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// One random operation. Fields that the operation ignores are random too.
	task automatic send_random_op();
		int   roll;
		op_t  code;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			code = OP_READ;
		end else if (roll < 45) begin
			code = OP_LOAD;
		end else begin
			code = op_t'($urandom_range(0, 5));
		end
		send_op(code, pick_index(), pick_index(), pick_index(),
			SH_W'($urandom_range(0, 31)), pick_word());
	endtask

	// Registers read as zero straight after reset, at both ends of the file.
	task automatic test_reset_state();
		send_op(OP_READ, 7'd0, 7'd0, 7'd127, 5'd31, 32'hFFFF_FFFF);
		send_op(OP_READ, 7'd127, 7'd127, 7'd0, 5'd0, 32'h0);
	endtask

	// Loads of the extreme words; reading all ones gives the largest sum.
	task automatic test_load_extremes();
		send_op(OP_LOAD, 7'd0, 7'd99, 7'd12, 5'd7, 32'hFFFF_FFFF);
		send_op(OP_LOAD, 7'd127, 7'd1, 7'd2, 5'd1, 32'h8000_0001);
		send_op(OP_LOAD, 7'd1, 7'd127, 7'd127, 5'd31, 32'h0000_0001);
		send_op(OP_LOAD, 7'd2, 7'd0, 7'd0, 5'd0, 32'hA5A5_A5A5);
		send_op(OP_READ, 7'd5, 7'd0, 7'd3, 5'd3, 32'h1234_5678);
		send_op(OP_READ, 7'd0, 7'd127, 7'd1, 5'd0, 32'h0);
		send_op(OP_LOAD, 7'd3, 7'd0, 7'd0, 5'd0, 32'h0);
	endtask

	// The bitwise operations, including a dest equal to its own source and
	// results that are consumed on the very next operation.
	task automatic test_bitwise_ops();
		send_op(OP_AND, 7'd3, 7'd0, 7'd2, 5'd9, 32'hDEAD_BEEF);
		send_op(OP_OR, 7'd4, 7'd1, 7'd127, 5'd0, 32'h0);
		send_op(OP_XOR, 7'd5, 7'd2, 7'd0, 5'd31, 32'h0);
		send_op(OP_NOT, 7'd2, 7'd2, 7'd77, 5'd17, 32'hFFFF_FFFF);
		send_op(OP_XOR, 7'd4, 7'd4, 7'd3, 5'd0, 32'h0);
		send_op(OP_READ, 7'd0, 7'd4, 7'd0, 5'd0, 32'h0);
		send_op(OP_READ, 7'd0, 7'd2, 7'd0, 5'd0, 32'h0);
		send_op(OP_READ, 7'd0, 7'd5, 7'd0, 5'd0, 32'h0);
	endtask

	// Shifts by the longest distance in both directions, by zero to the left and by one to the right.
	task automatic test_shifts();
		send_op(OP_SHL, 7'd6, 7'd0, 7'd55, 5'd31, 32'h5555_5555);
		send_op(OP_SHR, 7'd7, 7'd0, 7'd66, 5'd31, 32'h0);
		send_op(OP_SHL, 7'd8, 7'd127, 7'd0, 5'd0, 32'h0);
		send_op(OP_SHR, 7'd127, 7'd127, 7'd0, 5'd1, 32'h0);
		send_op(OP_READ, 7'd0, 7'd6, 7'd0, 5'd0, 32'h0);
		send_op(OP_READ, 7'd0, 7'd7, 7'd0, 5'd0, 32'h0);
		send_op(OP_READ, 7'd0, 7'd127, 7'd0, 5'd0, 32'h0);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// a mix of reads and writes. The internal queue fills, in_stall rises, and
	// the sender is left waiting until the hold-off ends. Afterwards the sender
	// pauses until every owed result is back.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 150;
		hold_id++;
		for (int i = 0; i < 40; i++) begin
			if (i % 2 == 0) begin
				send_op(OP_READ, pick_index(), pick_index(), pick_index(),
					SH_W'($urandom_range(0, 31)), pick_word());
			end else begin
				send_random_op();
			end
		end
		wait_results_drained();
	endtask

	// A stretch of random operations with the given idle and stall rates.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			send_random_op();
			// Once, halfway through, the sender goes quiet until the output side has caught up.
			if (i == count / 2) begin
				wait_results_drained();
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) begin
			reg_file_model[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_load_extremes();
		test_bitwise_ops();
		test_shifts();
		test_output_backpressure();
		test_random_traffic(13, 85, RAND_ITEMS);
		test_random_traffic(85, 13, RAND_ITEMS);
		test_random_traffic(0, 0, RAND_ITEMS);

		// All stimulus has transferred. Wait for the owed results, then keep the
		// clock running so that any stray result would show up.
		wait_results_drained();
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_reads.size() == 0) begin
			$display("bitwise_register_machine_fib_read: match");
		end else begin
			$display("bitwise_register_machine_fib_read: mismatch");
		end
		$finish;
	end

endmodule
